FILE: rtl/assert_macros.svh
// Assertion helpers shared by fct_queue and fct_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fct_pkg.sv
`timescale 1ns / 1ps

package fct_pkg;

    localparam int unsigned REQ_W   = 3;
    localparam int unsigned IDX_W   = 12;
    localparam int unsigned VAL_W   = 12;
    localparam int unsigned OFF_W   = 13;
    localparam int unsigned CNT_W   = 13;
    localparam int unsigned DATA_W  = 12;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    typedef logic [CNT_W-1:0] cnt_t;

    // request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_EXTEND = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PACKED = 3'd4;

    typedef enum logic [2:0] {
        OP_READ,
        OP_WRITE,
        OP_FIND,
        OP_EXTEND,
        OP_PACKED,
        OP_NONE
    } fct_op_t;

    // table values
    localparam logic [DATA_W-1:0] FAT_MEDIA = 12'hFF8;
    localparam logic [DATA_W-1:0] FAT_EOC   = 12'hFFF;
    localparam logic [DATA_W-1:0] FAT_FREE  = 12'h000;
    localparam cnt_t FIRST_DATA = 13'd2;
    localparam cnt_t CLUSTER_COUNT_RST = 13'd2880;

    // off / 3 == (off * 2731) >> 13, exact for every 13-bit offset
    localparam int unsigned RECIP_W     = 12;
    localparam int unsigned RECIP_SHIFT = 13;
    localparam int unsigned PROD_W      = OFF_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_3 = 12'd2731;

    localparam int unsigned QUEUE_DEPTH = 2;

    // register index sits above the byte-in-word bits
    localparam int unsigned CFG_IDX_LSB = 2;
    localparam logic [PADDR_W-CFG_IDX_LSB-1:0] CFG_IDX_CLUSTER_COUNT = 1'b0;

    typedef struct packed {
        fct_op_t             op;
        logic                idx_ok;
        logic [IDX_W-1:0]    idx;
        logic [VAL_W-1:0]    val;
        logic [OFF_W-1:0]    off;
        logic [IDX_W-1:0]    pair;
    } fct_item_t;

endpackage

FILE: rtl/fct_if.sv
`timescale 1ns / 1ps

interface fct_req_if;
    logic                        valid;
    logic                        ready;
    logic [fct_pkg::REQ_W-1:0]   req_type;
    logic [fct_pkg::IDX_W-1:0]   entry_index;
    logic [fct_pkg::VAL_W-1:0]   entry_value;
    logic [fct_pkg::OFF_W-1:0]   byte_offset;

    modport source (output valid, output req_type, output entry_index,
                    output entry_value, output byte_offset, input ready);
    modport sink   (input valid, input req_type, input entry_index,
                    input entry_value, input byte_offset, output ready);
endinterface

interface fct_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [fct_pkg::DATA_W-1:0]  result_data;
    logic                        status;

    modport source (output valid, output result_data, output status, input ready);
    modport sink   (input valid, input result_data, input status, output ready);
endinterface

FILE: rtl/fct_front.sv
`timescale 1ns / 1ps

module fct_front #(
    parameter int unsigned MAX_ENTRIES = 4096
) (
    fct_req_if.sink              req,
    input  logic                 q_full,
    input  logic                 init_done,
    output logic                 push,
    output fct_pkg::fct_item_t   item
);

    logic [fct_pkg::PROD_W-1:0] prod;

    assign req.ready = !q_full && init_done;
    assign push      = req.valid && req.ready;

    // pair index of the packed layout, off / 3 by reciprocal
    assign prod = fct_pkg::PROD_W'(req.byte_offset) * fct_pkg::PROD_W'(fct_pkg::RECIP_3);

    always_comb
    begin
        unique case (req.req_type)
            fct_pkg::REQ_READ:   item.op = fct_pkg::OP_READ;
            fct_pkg::REQ_WRITE:  item.op = fct_pkg::OP_WRITE;
            fct_pkg::REQ_FIND:   item.op = fct_pkg::OP_FIND;
            fct_pkg::REQ_EXTEND: item.op = fct_pkg::OP_EXTEND;
            fct_pkg::REQ_PACKED: item.op = fct_pkg::OP_PACKED;
            default:             item.op = fct_pkg::OP_NONE;
        endcase
        item.idx_ok = fct_pkg::cnt_t'(req.entry_index) < fct_pkg::cnt_t'(MAX_ENTRIES);
        item.idx    = req.entry_index;
        item.val    = req.entry_value;
        item.off    = req.byte_offset;
        item.pair   = prod[fct_pkg::RECIP_SHIFT +: fct_pkg::IDX_W];
    end

endmodule

FILE: rtl/fct_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fct_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fct_pkg::fct_item_t   item_in,
    output logic                 full,
    input  logic                 pop,
    output fct_pkg::fct_item_t   head,
    output logic                 not_empty
);

    localparam int unsigned PW = (fct_pkg::QUEUE_DEPTH > 1) ? $clog2(fct_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(fct_pkg::QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(fct_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(fct_pkg::QUEUE_DEPTH);

    fct_pkg::fct_item_t slots_reg [fct_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full      = count_reg == DEPTH_CNT;
    assign not_empty = count_reg != '0;
    assign head      = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not step up on push")

endmodule

FILE: rtl/fct_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fct_back #(
    parameter int unsigned MAX_ENTRIES = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fct_pkg::cnt_t               cluster_count,
    input  fct_pkg::fct_item_t          item,
    input  logic                        item_valid,
    output logic                        item_pop,
    output logic                        init_done,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [fct_pkg::DATA_W-1:0]  result_data,
    output logic                        status
);

    localparam int unsigned AW = $clog2(MAX_ENTRIES);
    localparam fct_pkg::cnt_t MAX_CNT = fct_pkg::cnt_t'(MAX_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_READ_WAIT,
        S_WRITE,
        S_MARK,
        S_SCAN,
        S_LINK,
        S_PK0,
        S_PK1,
        S_PK2
    } state_t;

    state_t state_reg;

    // table memory
    logic [fct_pkg::DATA_W-1:0] mem [MAX_ENTRIES];
    logic [fct_pkg::DATA_W-1:0] rdata_reg;
    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic [fct_pkg::DATA_W-1:0] mem_wd;
    logic                       mem_re;
    logic [AW-1:0]              mem_ra;

    // work item
    logic [AW-1:0]              clr_reg;
    fct_pkg::fct_op_t           op_reg;
    logic                       idx_ok_reg;
    logic [fct_pkg::IDX_W-1:0]  idx_reg;
    logic [fct_pkg::VAL_W-1:0]  val_reg;
    logic [fct_pkg::OFF_W-1:0]  off_reg;
    logic [fct_pkg::IDX_W-1:0]  pair_reg;

    // scan
    fct_pkg::cnt_t              issue_reg;
    logic [fct_pkg::IDX_W-1:0]  chk_reg;
    logic                       pend_reg;
    logic [fct_pkg::IDX_W-1:0]  found_reg;

    // packed byte
    logic [1:0]                 k_reg;
    logic                       pk_ok_reg;
    logic [fct_pkg::DATA_W-1:0] e0_reg;

    // result slot
    logic                       out_valid_reg;
    logic [fct_pkg::DATA_W-1:0] data_reg;
    logic                       status_reg;

    fct_pkg::cnt_t              lim;
    logic                       slot_free;
    logic                       scan_hit;
    logic                       scan_end;
    fct_pkg::cnt_t              pair2_e;
    fct_pkg::cnt_t              pair2_o;
    fct_pkg::cnt_t              three_pair;
    fct_pkg::cnt_t              k_diff;
    logic                       e0_ok;
    logic                       e1_ok;
    logic [fct_pkg::DATA_W-1:0] pk_e1;
    logic [fct_pkg::DATA_W-1:0] pk_byte;
    logic [fct_pkg::DATA_W-1:0] clr_val;
    logic                       load;
    logic [fct_pkg::DATA_W-1:0] ld_data;
    logic                       ld_status;

    assign lim       = (cluster_count > MAX_CNT) ? MAX_CNT : cluster_count;
    assign slot_free = !out_valid_reg || out_ready;
    assign item_pop  = (state_reg == S_IDLE) && item_valid && slot_free;
    assign init_done = state_reg != S_CLEAR;
    assign scan_hit  = (state_reg == S_SCAN) && pend_reg && (rdata_reg == fct_pkg::FAT_FREE);
    assign scan_end  = issue_reg >= lim;

    assign pair2_e    = {pair_reg, 1'b0};
    assign pair2_o    = {pair_reg, 1'b1};
    assign three_pair = fct_pkg::cnt_t'(pair_reg) + pair2_e;
    assign k_diff     = off_reg - three_pair;
    assign e0_ok      = pair2_e < MAX_CNT;
    assign e1_ok      = pair2_o < MAX_CNT;
    assign pk_e1      = pk_ok_reg ? rdata_reg : fct_pkg::FAT_FREE;

    assign out_valid   = out_valid_reg;
    assign result_data = data_reg;
    assign status      = status_reg;

    always_comb
    begin
        if (clr_reg == '0)
        begin
            clr_val = fct_pkg::FAT_MEDIA;
        end
        else if (clr_reg == AW'(1))
        begin
            clr_val = fct_pkg::FAT_EOC;
        end
        else
        begin
            clr_val = fct_pkg::FAT_FREE;
        end
    end

    // low byte, mixed nibbles, high byte of an entry pair
    always_comb
    begin
        case (k_reg)
            2'd0:    pk_byte = {4'b0, e0_reg[7:0]};
            2'd1:    pk_byte = {4'b0, pk_e1[3:0], e0_reg[11:8]};
            2'd2:    pk_byte = {4'b0, pk_e1[11:4]};
            default: pk_byte = '0;
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = idx_reg[AW-1:0];
        mem_wd = val_reg;
        mem_re = 1'b0;
        mem_ra = idx_reg[AW-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = clr_val;
            end
            S_READ:
            begin
                mem_re = 1'b1;
            end
            S_WRITE:
            begin
                mem_we = idx_ok_reg;
            end
            S_MARK:
            begin
                mem_we = idx_ok_reg;
                mem_wd = fct_pkg::FAT_EOC;
            end
            S_SCAN:
            begin
                mem_re = !scan_hit && !scan_end;
                mem_ra = issue_reg[AW-1:0];
            end
            S_LINK:
            begin
                mem_we = idx_ok_reg;
                mem_wd = found_reg;
            end
            S_PK0:
            begin
                mem_re = e0_ok;
                mem_ra = pair2_e[AW-1:0];
            end
            S_PK1:
            begin
                mem_re = e1_ok;
                mem_ra = pair2_o[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // result load into the output slot
    always_comb
    begin
        load      = 1'b0;
        ld_data   = '0;
        ld_status = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                load = item_pop && ((item.op == fct_pkg::OP_NONE) ||
                                    ((item.op == fct_pkg::OP_READ) && !item.idx_ok));
            end
            S_READ_WAIT:
            begin
                load    = 1'b1;
                ld_data = rdata_reg;
            end
            S_WRITE:
            begin
                load = 1'b1;
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    load    = !((op_reg == fct_pkg::OP_EXTEND) && idx_ok_reg);
                    ld_data = chk_reg;
                end
                else if (scan_end)
                begin
                    load      = 1'b1;
                    ld_status = 1'b1;
                end
            end
            S_LINK:
            begin
                load    = 1'b1;
                ld_data = found_reg;
            end
            S_PK2:
            begin
                load    = 1'b1;
                ld_data = pk_byte;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            op_reg        <= fct_pkg::OP_NONE;
            idx_ok_reg    <= 1'b0;
            idx_reg       <= '0;
            val_reg       <= '0;
            off_reg       <= '0;
            pair_reg      <= '0;
            issue_reg     <= '0;
            chk_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= '0;
            k_reg         <= '0;
            pk_ok_reg     <= 1'b0;
            e0_reg        <= '0;
            out_valid_reg <= 1'b0;
            data_reg      <= '0;
            status_reg    <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                data_reg      <= ld_data;
                status_reg    <= ld_status;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (item_pop)
                    begin
                        op_reg     <= item.op;
                        idx_ok_reg <= item.idx_ok;
                        idx_reg    <= item.idx;
                        val_reg    <= item.val;
                        off_reg    <= item.off;
                        pair_reg   <= item.pair;
                        issue_reg  <= fct_pkg::FIRST_DATA;
                        pend_reg   <= 1'b0;
                        unique case (item.op)
                            fct_pkg::OP_READ:   state_reg <= item.idx_ok ? S_READ : S_IDLE;
                            fct_pkg::OP_WRITE:  state_reg <= S_WRITE;
                            fct_pkg::OP_FIND:   state_reg <= S_SCAN;
                            fct_pkg::OP_EXTEND: state_reg <= S_MARK;
                            fct_pkg::OP_PACKED: state_reg <= S_PK0;
                            default:            state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_READ_WAIT;
                end
                S_MARK:
                begin
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (scan_hit)
                    begin
                        found_reg <= chk_reg;
                        state_reg <= ((op_reg == fct_pkg::OP_EXTEND) && idx_ok_reg) ?
                                     S_LINK : S_IDLE;
                    end
                    else if (scan_end)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        chk_reg   <= issue_reg[fct_pkg::IDX_W-1:0];
                        issue_reg <= issue_reg + 1'b1;
                        pend_reg  <= 1'b1;
                    end
                end
                S_PK0:
                begin
                    k_reg     <= k_diff[1:0];
                    pk_ok_reg <= e0_ok;
                    state_reg <= S_PK1;
                end
                S_PK1:
                begin
                    e0_reg    <= pk_ok_reg ? rdata_reg : fct_pkg::FAT_FREE;
                    pk_ok_reg <= e1_ok;
                    state_reg <= S_PK2;
                end
                default:
                begin
                    // read wait, write, link and last packed step all finish here
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_slot_free, clk, rst_n, load, slot_free, "result loaded over an untaken result")
    `ASSERT_IMPLIES(a_hit_range, clk, rst_n, scan_hit, (fct_pkg::cnt_t'(chk_reg) >= fct_pkg::FIRST_DATA) && (fct_pkg::cnt_t'(chk_reg) < lim), "free hit outside the search window")
    `ASSERT_NEXT(a_pk_byte, clk, rst_n, load && (state_reg == S_PK2), data_reg[11:8] == 4'b0, "packed byte wider than eight bits")

endmodule

FILE: rtl/fat12_cluster_table_engine_top.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle for an unknown code or out-of-range read while
// rsp.ready is high; any other request holds the back until its result is loaded, and a
// search reads the table one entry at a time through its single read port.
// Reset: async active-low; a clearing pass then writes all MAX_ENTRIES entries, one per
// cycle, with req.ready low; configuration writes are taken throughout.

module fat12_cluster_table_engine_top #(
    parameter int unsigned MAX_ENTRIES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fct_req_if.sink                       req,
    fct_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fct_pkg::PADDR_W-1:0]   paddr,
    input  logic [fct_pkg::PDATA_W-1:0]   pwdata,
    output logic [fct_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    // Structure:
    //   fct_front  - takes request transfers, decodes the request code, checks the
    //                entry index against the table size and works out the packed
    //                pair index (offset / 3 by reciprocal multiply).
    //   fct_queue  - two-deep queue; the front keeps accepting while the back is busy
    //                with a long free search or its result waits on rsp.ready.
    //   fct_back   - sequencer around the one-read-port table memory: reads, writes,
    //                linear free search (one entry per cycle, pipelined with the
    //                registered read), chain extend, packed byte assembly, and the
    //                registered output slot.

    fct_pkg::cnt_t       cluster_count_reg;
    logic                cfg_wr;
    logic                cfg_sel;

    logic                q_full;
    logic                q_not_empty;
    logic                q_push;
    logic                q_pop;
    logic                init_done;
    fct_pkg::fct_item_t  front_item;
    fct_pkg::fct_item_t  q_head;

    // APB register file: one register, cluster_count at byte address 0.
    // Writes land at the access phase; other addresses are ignored.
    assign pready  = 1'b1;
    assign cfg_sel = paddr[fct_pkg::PADDR_W-1:fct_pkg::CFG_IDX_LSB] ==
                     fct_pkg::CFG_IDX_CLUSTER_COUNT;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = cfg_sel ? fct_pkg::PDATA_W'(cluster_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= fct_pkg::CLUSTER_COUNT_RST;
        end
        else if (cfg_wr && cfg_sel)
        begin
            cluster_count_reg <= pwdata[fct_pkg::CNT_W-1:0];
        end
    end

    fct_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .req       (req),
        .q_full    (q_full),
        .init_done (init_done),
        .push      (q_push),
        .item      (front_item)
    );

    fct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .item_in   (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    // the back pops only when the output slot is free or emptying this cycle,
    // so a result can always be loaded when its work finishes
    fct_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cluster_count (cluster_count_reg),
        .item          (q_head),
        .item_valid    (q_not_empty),
        .item_pop      (q_pop),
        .init_done     (init_done),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .result_data   (rsp.result_data),
        .status        (rsp.status)
    );

endmodule
